[design/chacha20_block_function_assert.svh]
// Assertion macros for the checker file of this block.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef CHACHA20_BLOCK_FUNCTION_ASSERT_SVH
`define CHACHA20_BLOCK_FUNCTION_ASSERT_SVH

// Same-cycle implication.
`define CBF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CBF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/cbf_pkg.sv]
package cbf_pkg;

  // Word and state geometry.
  localparam int WORD_W         = 32;
  localparam int NUM_WORDS      = 16;
  localparam int ROUNDS_DEFAULT = 20;

  typedef logic [WORD_W-1:0]              word_t;
  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] state_t;

  // Payload that travels down the round pipeline.
  typedef struct packed {
    state_t x;     // working state
    state_t init;  // original input, kept for the final addition
  } pipe_t;

  // One half of a full round: the first or second pair of add/xor/rotate
  // steps of all four quarter-rounds, on columns or on diagonals.
  function automatic state_t half_round(state_t x, logic diag, logic second);
    state_t     y;
    word_t      a;
    word_t      b;
    word_t      c;
    word_t      d;
    logic [1:0] q2;
    logic [1:0] bi;
    logic [1:0] ci;
    logic [1:0] di;
    y = x;
    for (int q = 0; q < 4; q++) begin
      q2 = 2'(q);
      // Diagonals shift each row by its row number.
      bi = diag ? q2 + 2'd1 : q2;
      ci = diag ? q2 + 2'd2 : q2;
      di = diag ? q2 + 2'd3 : q2;
      a  = y[{2'd0, q2}];
      b  = y[{2'd1, bi}];
      c  = y[{2'd2, ci}];
      d  = y[{2'd3, di}];
      a  = a + b;
      d  = d ^ a;
      d  = second ? {d[23:0], d[31:24]} : {d[15:0], d[31:16]};
      c  = c + d;
      b  = b ^ c;
      b  = second ? {b[24:0], b[31:25]} : {b[19:0], b[31:20]};
      y[{2'd0, q2}] = a;
      y[{2'd1, bi}] = b;
      y[{2'd2, ci}] = c;
      y[{2'd3, di}] = d;
    end
    return y;
  endfunction

endpackage

[design/cbf_round_stage.sv]
module cbf_round_stage #(
  parameter bit DIAG   = 1'b0,
  parameter bit SECOND = 1'b0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  cbf_pkg::pipe_t in_data,
  output logic          out_valid,
  output cbf_pkg::pipe_t out_data
);

  logic           valid_r;
  cbf_pkg::pipe_t data_r;
  cbf_pkg::pipe_t data_nxt;

  // Half round on the working state; the original input rides along.
  always_comb begin
    data_nxt.x    = cbf_pkg::half_round(in_data.x, DIAG, SECOND);
    data_nxt.init = in_data.init;
  end

  // Valid bit is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  // Payload is loaded only when a request is present.
  always_ff @(posedge clk) begin
    if (in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

[design/cbf_final_add.sv]
module cbf_final_add (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  cbf_pkg::pipe_t  in_data,
  output logic            out_valid,
  output cbf_pkg::state_t out_state
);

  logic            valid_r;
  cbf_pkg::state_t sum_r;
  cbf_pkg::state_t sum_nxt;

  // Word-wise feed-forward of the original input, modulo 2^32.
  always_comb begin
    for (int i = 0; i < cbf_pkg::NUM_WORDS; i++) begin
      sum_nxt[i] = in_data.x[i] + in_data.init[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      sum_r <= sum_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_state = sum_r;

endmodule

[design/chacha20_block_function.sv]
// ChaCha block function, fully unrolled round pipeline.
// Input channel: a request (one 16-word state on in_w0_w1 .. in_w14_w15, the
// lower-numbered word of each pair in bits 31:0) is taken at a rising edge
// where start is high and busy is low. busy is always low, so a new request
// may be issued in every cycle.
// Result channel: out_valid is high for exactly one cycle while the 16-word
// keystream block is on out_w0_w1 .. out_w14_w15.
// Each round is split into two register stages of two chained adds each,
// followed by one stage for the final word-wise addition.
// Throughput: one block per cycle, set by the one-request-per-cycle pipeline.
// Reset (rst_n low, synchronous) clears every valid bit; requests in flight
// are dropped and no result appears until a new request passes through.
// The receiver cannot stall: each result is shown for one cycle only.
module chacha20_block_function #(
  parameter int ROUNDS = cbf_pkg::ROUNDS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_w0_w1,
  input  logic [63:0] in_w2_w3,
  input  logic [63:0] in_w4_w5,
  input  logic [63:0] in_w6_w7,
  input  logic [63:0] in_w8_w9,
  input  logic [63:0] in_w10_w11,
  input  logic [63:0] in_w12_w13,
  input  logic [63:0] in_w14_w15,
  output logic        out_valid,
  output logic [63:0] out_w0_w1,
  output logic [63:0] out_w2_w3,
  output logic [63:0] out_w4_w5,
  output logic [63:0] out_w6_w7,
  output logic [63:0] out_w8_w9,
  output logic [63:0] out_w10_w11,
  output logic [63:0] out_w12_w13,
  output logic [63:0] out_w14_w15
);

  localparam int NSTAGE = 2 * ROUNDS;

  cbf_pkg::state_t in_state;
  cbf_pkg::state_t ks_state;
  cbf_pkg::pipe_t  stage_data [NSTAGE+1];
  logic            stage_valid[NSTAGE+1];

  // The pipeline never holds requests off.
  assign busy = 1'b0;

  // Unpack the input pairs into state words.
  assign in_state[0]  = in_w0_w1[31:0];
  assign in_state[1]  = in_w0_w1[63:32];
  assign in_state[2]  = in_w2_w3[31:0];
  assign in_state[3]  = in_w2_w3[63:32];
  assign in_state[4]  = in_w4_w5[31:0];
  assign in_state[5]  = in_w4_w5[63:32];
  assign in_state[6]  = in_w6_w7[31:0];
  assign in_state[7]  = in_w6_w7[63:32];
  assign in_state[8]  = in_w8_w9[31:0];
  assign in_state[9]  = in_w8_w9[63:32];
  assign in_state[10] = in_w10_w11[31:0];
  assign in_state[11] = in_w10_w11[63:32];
  assign in_state[12] = in_w12_w13[31:0];
  assign in_state[13] = in_w12_w13[63:32];
  assign in_state[14] = in_w14_w15[31:0];
  assign in_state[15] = in_w14_w15[63:32];

  assign stage_valid[0]     = start && !busy;
  assign stage_data[0].x    = in_state;
  assign stage_data[0].init = in_state;

  // Two stages per round; rounds alternate column and diagonal.
  for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
    localparam bit DIAG   = ((s / 2) % 2) == 1;
    localparam bit SECOND = (s % 2) == 1;
    cbf_round_stage #(
      .DIAG  (DIAG),
      .SECOND(SECOND)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (stage_valid[s]),
      .in_data  (stage_data[s]),
      .out_valid(stage_valid[s+1]),
      .out_data (stage_data[s+1])
    );
  end

  // Feed-forward addition and output register.
  cbf_final_add u_final (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (stage_valid[NSTAGE]),
    .in_data  (stage_data[NSTAGE]),
    .out_valid(out_valid),
    .out_state(ks_state)
  );

  // Pack the keystream words into output pairs.
  assign out_w0_w1   = {ks_state[1],  ks_state[0]};
  assign out_w2_w3   = {ks_state[3],  ks_state[2]};
  assign out_w4_w5   = {ks_state[5],  ks_state[4]};
  assign out_w6_w7   = {ks_state[7],  ks_state[6]};
  assign out_w8_w9   = {ks_state[9],  ks_state[8]};
  assign out_w10_w11 = {ks_state[11], ks_state[10]};
  assign out_w12_w13 = {ks_state[13], ks_state[12]};
  assign out_w14_w15 = {ks_state[15], ks_state[14]};

endmodule

[design/cbf_checker.sv]
`include "chacha20_block_function_assert.svh"

module cbf_checker #(
  parameter int ROUNDS = cbf_pkg::ROUNDS_DEFAULT
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [63:0] in_w0_w1,
  input logic [63:0] in_w2_w3,
  input logic [63:0] in_w4_w5,
  input logic [63:0] in_w6_w7,
  input logic [63:0] in_w8_w9,
  input logic [63:0] in_w10_w11,
  input logic [63:0] in_w12_w13,
  input logic [63:0] in_w14_w15,
  input logic        out_valid,
  input logic [63:0] out_w0_w1,
  input logic [63:0] out_w2_w3,
  input logic [63:0] out_w4_w5,
  input logic [63:0] out_w6_w7,
  input logic [63:0] out_w8_w9,
  input logic [63:0] out_w10_w11,
  input logic [63:0] out_w12_w13,
  input logic [63:0] out_w14_w15
);

  localparam int LAT = 2 * ROUNDS + 1;

  logic           req_acc;
  logic           req_zero;
  logic           out_zero;
  logic [LAT-1:0] acc_hist_r;
  logic [LAT-1:0] zero_hist_r;

  assign req_acc  = start && !busy;
  assign req_zero = (in_w0_w1 == '0) && (in_w2_w3 == '0) && (in_w4_w5 == '0) &&
                    (in_w6_w7 == '0) && (in_w8_w9 == '0) && (in_w10_w11 == '0) &&
                    (in_w12_w13 == '0) && (in_w14_w15 == '0);

  // The keystream block shown on the result ports is all zero.
  assign out_zero = (out_w0_w1 == '0) && (out_w2_w3 == '0) && (out_w4_w5 == '0) &&
                    (out_w6_w7 == '0) && (out_w8_w9 == '0) && (out_w10_w11 == '0) &&
                    (out_w12_w13 == '0) && (out_w14_w15 == '0);

  // Track accepted requests, and which of them were all-zero states.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_hist_r  <= '0;
      zero_hist_r <= '0;
    end else begin
      acc_hist_r  <= {acc_hist_r[LAT-2:0], req_acc};
      zero_hist_r <= {zero_hist_r[LAT-2:0], req_acc && req_zero};
    end
  end

  `CBF_ASSERT_NOW(a_busy_low, 1'b1, !busy, "busy raised after reset")
  `CBF_ASSERT_NOW(a_valid_lat, 1'b1, out_valid == acc_hist_r[LAT-1], "out_valid latency mismatch")
  `CBF_ASSERT_NOW(a_zero_block, out_valid && zero_hist_r[LAT-1], out_zero, "zero state gave nonzero keystream")

endmodule

bind chacha20_block_function cbf_checker #(.ROUNDS(ROUNDS)) u_cbf_checker (.*);

[sim/chacha20_block_function_tb.sv]
`timescale 1ns / 1ps

// Sixteen 32-bit state words, packed as the block packs them: word i sits in
// bits 32*i+31:32*i, so element k of the outer dimension is port pair w2k_w2k+1.
typedef logic [7:0][63:0] block_t;

// Left rotation of one state word.
function automatic cbf_pkg::word_t rotl_word(cbf_pkg::word_t v, int unsigned n);
  return (v << n) | (v >> (32 - n));
endfunction

// One quarter-round on words a, b, c and d of the working state.
function automatic cbf_pkg::state_t quarter_mix(cbf_pkg::state_t s, int a, int b,
                                               int c, int d);
  s[a] = s[a] + s[b];
  s[d] = rotl_word(s[d] ^ s[a], 16);
  s[c] = s[c] + s[d];
  s[b] = rotl_word(s[b] ^ s[c], 12);
  s[a] = s[a] + s[b];
  s[d] = rotl_word(s[d] ^ s[a], 8);
  s[c] = s[c] + s[d];
  s[b] = rotl_word(s[b] ^ s[c], 7);
  return s;
endfunction

// Expected keystream block for one input state: column rounds on even round
// numbers, diagonal rounds on odd ones, then the feed-forward addition.
function automatic block_t chacha_keystream(block_t blk, int rounds);
  cbf_pkg::state_t init_words;
  cbf_pkg::state_t x;
  init_words = blk;
  x = init_words;
  for (int r = 0; r < rounds; r++) begin
    for (int q = 0; q < 4; q++) begin
      if (r % 2 == 0) begin
        x = quarter_mix(x, q, 4 + q, 8 + q, 12 + q);
      end else begin
        x = quarter_mix(x, q, 4 + (q + 1) % 4, 8 + (q + 2) % 4, 12 + (q + 3) % 4);
      end
    end
  end
  for (int i = 0; i < cbf_pkg::NUM_WORDS; i++) begin
    x[i] = x[i] + init_words[i];
  end
  return x;
endfunction

// Holds the keystream blocks still owed by the block, oldest first.
class keystream_scoreboard;
  block_t      expected_q[$];
  int unsigned failures;
  int          rounds;

  function new(int rounds_i);
    rounds   = rounds_i;
    failures = 0;
  endfunction

  function void note_request(block_t state_in);
    expected_q.push_back(chacha_keystream(state_in, rounds));
  endfunction

  function void check_block(block_t got);
    block_t want;
    if (expected_q.size() == 0) begin
      $error("keystream block with no request outstanding: %h", got);
      failures++;
      return;
    end
    want = expected_q.pop_front();
    for (int i = 0; i < 8; i++) begin
      if (got[i] !== want[i]) begin
        $error("out_w%0d_w%0d mismatch: expected %h, actual %h",
               2 * i, 2 * i + 1, want[i], got[i]);
        failures++;
      end
    end
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction
endclass

module chacha20_block_function_tb;

  localparam int          NUM_ROUNDS       = cbf_pkg::ROUNDS_DEFAULT;
  localparam int          LATENCY          = 2 * NUM_ROUNDS + 1;
  localparam int          RANDOM_PER_PHASE = 385;
  localparam int          NUM_DIRECTED     = 14;
  localparam int unsigned CYCLE_LIMIT      = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  block_t      in_blk = '0;
  logic        busy;
  logic        out_valid;
  logic [63:0] out_w0_w1, out_w2_w3, out_w4_w5, out_w6_w7;
  logic [63:0] out_w8_w9, out_w10_w11, out_w12_w13, out_w14_w15;
  block_t      out_blk;

  keystream_scoreboard sb;
  int unsigned         cycle_count = 0;

  assign out_blk = {out_w14_w15, out_w12_w13, out_w10_w11, out_w8_w9,
                    out_w6_w7, out_w4_w5, out_w2_w3, out_w0_w1};

  chacha20_block_function #(
    .ROUNDS(NUM_ROUNDS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_w0_w1   (in_blk[0]),
    .in_w2_w3   (in_blk[1]),
    .in_w4_w5   (in_blk[2]),
    .in_w6_w7   (in_blk[3]),
    .in_w8_w9   (in_blk[4]),
    .in_w10_w11 (in_blk[5]),
    .in_w12_w13 (in_blk[6]),
    .in_w14_w15 (in_blk[7]),
    .out_valid  (out_valid),
    .out_w0_w1  (out_w0_w1),
    .out_w2_w3  (out_w2_w3),
    .out_w4_w5  (out_w4_w5),
    .out_w6_w7  (out_w6_w7),
    .out_w8_w9  (out_w8_w9),
    .out_w10_w11(out_w10_w11),
    .out_w12_w13(out_w12_w13),
    .out_w14_w15(out_w14_w15)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: a hung pipeline or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Monitor: a request is taken when start is high and busy low; every strobed
  // result is checked against the oldest outstanding prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        sb.check_block(out_blk);
      end
      if (start && !busy) begin
        sb.note_request(in_blk);
      end
    end
  end

  // Present one request from the falling edge on and hold it until taken.
  task automatic send_request(block_t blk);
    @(negedge clk);
    start  <= 1'b1;
    in_blk <= blk;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_idle(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Hand-picked states: field extremes, single bits, carry chains and the
  // standard test vector with its constant words and counter.
  function automatic block_t directed_state(int k);
    cbf_pkg::state_t s;
    s = '0;
    case (k)
      0: s = '0;
      1: s = '1;
      2: begin
        s = {32'h00000000, 32'h4a000000, 32'h09000000, 32'h00000001,
             32'h1f1e1d1c, 32'h1b1a1918, 32'h17161514, 32'h13121110,
             32'h0f0e0d0c, 32'h0b0a0908, 32'h07060504, 32'h03020100,
             32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865};
      end
      3: s = {16{32'h55555555}};
      4: s = {16{32'haaaaaaaa}};
      5: s = {16{32'h80000000}};
      6: s = {16{32'h00000001}};
      7: s[0] = 32'h00000001;
      8: s[15] = 32'h80000000;
      9: begin
        for (int i = 0; i < 16; i++) s[i] = i;
      end
      10: begin
        for (int i = 0; i < 16; i++) s[i] = (i % 2 == 0) ? 32'hffffffff : 32'h0;
      end
      11: begin
        for (int i = 0; i < 16; i++) s[i] = (i % 2 == 0) ? 32'h0 : 32'hffffffff;
      end
      12: s = {16{32'h7fffffff}};
      default: s = {16{32'hfffffffe}};
    endcase
    return s;
  endfunction

  // Random state: mostly uniform words, some built from edge values, some with
  // the usual constant words in front.
  function automatic block_t random_state();
    cbf_pkg::state_t s;
    int              kind;
    kind = $urandom_range(9);
    for (int i = 0; i < 16; i++) begin
      s[i] = $urandom;
      if (kind == 0) begin
        case ($urandom_range(3))
          0: s[i] = 32'h0;
          1: s[i] = 32'hffffffff;
          2: s[i] = 32'h1 << $urandom_range(31);
          default: s[i] = ~(32'h1 << $urandom_range(31));
        endcase
      end
    end
    if (kind == 1) begin
      s[0] = 32'h61707865;
      s[1] = 32'h3320646e;
      s[2] = 32'h79622d32;
      s[3] = 32'h6b206574;
    end
    return s;
  endfunction

  // One phase of random requests. In chunks of 50 requests, about a quarter
  // run back to back whatever the idle rate is.
  task automatic run_phase(int idle_pct);
    int  gap;
    bit  quiet;
    quiet = 1'b0;
    for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
      if (n % 50 == 0) quiet = ($urandom_range(3) == 0);
      gap = 0;
      if (!quiet) begin
        while ($urandom_range(99) < idle_pct && gap < 40) gap++;
      end
      hold_idle(gap);
      send_request(random_state());
    end
  endtask

  initial begin
    sb = new(NUM_ROUNDS);
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests, back to back.
    for (int k = 0; k < NUM_DIRECTED; k++) begin
      send_request(directed_state(k));
    end
    hold_idle(3);

    // Random phases with different request idle rates; the result side has no stall.
    run_phase(0);
    run_phase(79);
    run_phase(0);
    run_phase(10);
    hold_idle(1);

    // Drain the pipeline, then allow stray results to show up.
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    if (sb.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
